>>> design/nfft_pkg.sv
// Package for the netboot frame filter and tracker.
// Holds the item structs, verdict and phase codes, frame layout constants and
// the per-byte CRC-32 step. No dependencies.
package nfft_pkg;

  localparam int MAX_FRAME = 2048;
  localparam int IDX_W     = $clog2(MAX_FRAME + 1);
  localparam int LEN_W     = 12;

  localparam logic [31:0] CRC_POLY        = 32'hedb88320;
  localparam logic [15:0] ETHERTYPE_RESET = 16'h8abc;
  localparam logic [7:0]  PREAMBLE_BYTE   = 8'h55;
  localparam logic [7:0]  SFD_BYTE        = 8'hd5;

  // Byte positions within the frame, preamble included
  localparam int PREAMBLE_LEN = 8;
  localparam int SFD_POS      = 7;
  localparam int CRC_START    = 12;
  localparam int TYPE_HI_POS  = 20;
  localparam int TYPE_LO_POS  = 21;
  localparam int CMD_POS      = 22;
  localparam int ARG_POS      = 26;
  localparam int HDR_LEN      = 26;
  localparam int MIN_CMD_LEN  = 4;
  localparam int MIN_ARG_LEN  = 8;

  localparam logic [31:0] CMD_SET_SIZE = 32'd0;
  localparam logic [31:0] CMD_COPY     = 32'd1;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_SHORT        = 3'd1,
    ST_BAD_PREAMBLE = 3'd2,
    ST_BAD_TYPE     = 3'd3,
    ST_BAD_CRC      = 3'd4,
    ST_TOO_LONG     = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    PH_WAIT_SIZE = 2'd0,
    PH_RECEIVING = 2'd1,
    PH_DONE      = 2'd2
  } phase_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_last;
  } rx_item_t;

  typedef struct packed {
    status_t          frame_status;
    logic [31:0]      command_code;
    logic [LEN_W-1:0] payload_length;
    logic             copy_enable;
    logic [31:0]      copy_offset;
    logic [LEN_W-1:0] copy_length;
    logic [31:0]      bytes_received;
    logic [31:0]      image_size;
    phase_t           boot_phase;
  } result_t;

  typedef struct packed {
    logic [IDX_W-1:0] byte_index;
    logic             length_overflow;
    logic             preamble_good;
    logic [31:0]      crc;
    logic [31:0]      tail;
    logic [15:0]      ether_type;
    logic [31:0]      command;
    logic [31:0]      argument;
  } frame_state_t;

  localparam frame_state_t FRAME_CLEAR = '{
    byte_index:      '0,
    length_overflow: 1'b0,
    preamble_good:   1'b1,
    crc:             32'hffffffff,
    tail:            '0,
    ether_type:      '0,
    command:         '0,
    argument:        '0
  };

  // Reflected CRC-32, one byte per call
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] data);
    logic [31:0] c;
    c = crc_in ^ {24'd0, data};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
    end
    return c;
  endfunction

endpackage

>>> design/netboot_frame_filter_and_tracker.sv
// Top level of the netboot frame filter and tracker.
// Depends on nfft_pkg for item structs, codes and the CRC step.
//
// Usage:
//   in channel  (in_valid/in_ready/in_item): one received byte per item,
//     preamble first and FCS last, frame_last set on the final byte.
//   out channel (out_valid/out_ready/out_item): one verdict per frame, with
//     the image bookkeeping as it stands after that frame.
//   cfg channel (cfg_valid/cfg_ready/cfg_data): the accepted ethertype; always
//     ready, write only while no frame is in flight.
// Throughput: one byte per cycle while in_ready is high; the CRC is advanced a whole byte per cycle.
// Pipeline: the frame state of the last byte is registered into the frame-end
//   stage, and the verdict computed there is registered into the output register
//   once that register is free, which raises out_valid.
// Stalls: while a verdict waits in the frame-end stage behind a result the
//   receiver has not taken, in_ready is low for every byte; it returns as soon
//   as the receiver takes the held result.
// Reset: clears the frame state, drops any pending verdict, sets the image
//   phase to awaiting size with zero counts, and the ethertype to 0x8abc.
module netboot_frame_filter_and_tracker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  nfft_pkg::rx_item_t in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output nfft_pkg::result_t  out_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        cfg_data
);
  import nfft_pkg::*;

  logic [15:0]  ethertype;
  frame_state_t frame, frame_next;
  frame_state_t snap;
  logic         snap_valid;
  logic         in_fire, advance;

  phase_t       phase, phase_next;
  logic [31:0]  received_count, received_count_next;
  logic [31:0]  total_size, total_size_next;
  result_t      result_next;

  assign cfg_ready = 1'b1;
  assign advance   = !out_valid || out_ready;
  assign in_ready  = !snap_valid || advance;
  assign in_fire   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ethertype <= ETHERTYPE_RESET;
    end else if (cfg_valid) begin
      ethertype <= cfg_data;
    end
  end

  // Byte stage: advance the per-frame state
  always_comb begin
    logic [IDX_W-1:0] idx;
    logic [7:0]       b;
    idx        = frame.byte_index;
    b          = in_item.rx_byte;
    frame_next = frame;
    if (idx >= IDX_W'(MAX_FRAME)) begin
      frame_next.length_overflow = 1'b1;
    end else begin
      if (idx < IDX_W'(PREAMBLE_LEN)) begin
        if (b != ((idx == IDX_W'(SFD_POS)) ? SFD_BYTE : PREAMBLE_BYTE)) begin
          frame_next.preamble_good = 1'b0;
        end
      end else begin
        // FCS candidate sits in the tail; CRC sees bytes four positions late
        if (idx >= IDX_W'(CRC_START)) begin
          frame_next.crc = crc_byte(frame.crc, frame.tail[7:0]);
        end
        frame_next.tail = {b, frame.tail[31:8]};
      end
      if (idx == IDX_W'(TYPE_HI_POS)) begin
        frame_next.ether_type[15:8] = b;
      end
      if (idx == IDX_W'(TYPE_LO_POS)) begin
        frame_next.ether_type[7:0] = b;
      end
      for (int j = 0; j < 4; j++) begin
        if (idx == IDX_W'(CMD_POS + j)) begin
          frame_next.command[8*j +: 8] = b;
        end
        if (idx == IDX_W'(ARG_POS + j)) begin
          frame_next.argument[8*j +: 8] = b;
        end
      end
      frame_next.byte_index = idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame      <= FRAME_CLEAR;
      snap_valid <= 1'b0;
    end else begin
      if (in_fire) begin
        frame <= in_item.frame_last ? FRAME_CLEAR : frame_next;
      end
      if (in_fire && in_item.frame_last) begin
        snap_valid <= 1'b1;
      end else if (advance) begin
        snap_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_item.frame_last) begin
      snap <= frame_next;
    end
  end

  // Frame-end stage: verdict and image bookkeeping
  always_comb begin
    logic [IDX_W-1:0] plen;
    logic [IDX_W-1:0] data_len;
    logic [32:0]      chunk_end;
    logic             frame_ok;
    logic             act;
    logic             do_copy;
    status_t          status;

    plen      = snap.byte_index - IDX_W'(HDR_LEN);
    data_len  = plen - IDX_W'(MIN_ARG_LEN);
    chunk_end = {1'b0, snap.argument} + 33'(data_len);

    priority if (snap.byte_index < IDX_W'(HDR_LEN)) begin
      status = ST_SHORT;
    end else if (snap.length_overflow) begin
      status = ST_TOO_LONG;
    end else if (!snap.preamble_good) begin
      status = ST_BAD_PREAMBLE;
    end else if (snap.ether_type != ethertype) begin
      status = ST_BAD_TYPE;
    end else if (~snap.crc != snap.tail) begin
      status = ST_BAD_CRC;
    end else begin
      status = ST_OK;
    end

    frame_ok = (status == ST_OK);
    act      = frame_ok && (plen >= IDX_W'(MIN_ARG_LEN));
    do_copy  = act && (phase == PH_RECEIVING) && (snap.command == CMD_COPY)
               && (snap.argument <= received_count)
               && (chunk_end > {1'b0, received_count});

    phase_next          = phase;
    received_count_next = received_count;
    total_size_next     = total_size;
    if (act && (phase == PH_WAIT_SIZE) && (snap.command == CMD_SET_SIZE)) begin
      total_size_next = snap.argument;
      phase_next      = (received_count >= snap.argument) ? PH_DONE : PH_RECEIVING;
    end
    if (do_copy) begin
      // saturate the count at all ones
      received_count_next = chunk_end[32] ? 32'hffffffff : chunk_end[31:0];
      if (chunk_end >= {1'b0, total_size}) begin
        phase_next = PH_DONE;
      end
    end

    result_next.frame_status   = status;
    result_next.command_code   = (frame_ok && plen >= IDX_W'(MIN_CMD_LEN)) ? snap.command : '0;
    result_next.payload_length = frame_ok ? LEN_W'(plen) : '0;
    result_next.copy_enable    = do_copy;
    result_next.copy_offset    = do_copy ? snap.argument : '0;
    result_next.copy_length    = do_copy ? LEN_W'(data_len) : '0;
    result_next.bytes_received = received_count_next;
    result_next.image_size     = total_size_next;
    result_next.boot_phase     = phase_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid      <= 1'b0;
      phase          <= PH_WAIT_SIZE;
      received_count <= '0;
      total_size     <= '0;
    end else if (snap_valid && advance) begin
      out_valid      <= 1'b1;
      phase          <= phase_next;
      received_count <= received_count_next;
      total_size     <= total_size_next;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_valid && advance) begin
      out_item <= result_next;
    end
  end

endmodule

>>> design/nfft_checker.sv
// Port-level checker for the netboot frame filter and tracker, with its bind.
// Depends on nfft_pkg for the item structs and codes.
module nfft_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input nfft_pkg::result_t  out_item
);
  import nfft_pkg::*;

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  // a taken result always frees the input side
  a_in_ready: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("input stalled while the receiver is ready");

  a_reject_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.frame_status != ST_OK |->
      out_item.command_code == '0 && out_item.payload_length == '0 &&
      !out_item.copy_enable)
    else $error("rejected frame carries payload fields");

  a_copy_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.copy_enable |->
      out_item.copy_length == out_item.payload_length - LEN_W'(MIN_ARG_LEN) &&
      out_item.copy_offset < out_item.bytes_received)
    else $error("copy fields inconsistent");

  a_wait_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.boot_phase == PH_WAIT_SIZE |->
      out_item.bytes_received == '0)
    else $error("bytes counted before image size");

endmodule

bind netboot_frame_filter_and_tracker nfft_checker u_nfft_checker (.*);
